FILE: sv/u8cw_pkg.sv
// Shared types, constants and the display-width lookup for the UTF-8 width decoder.
// No dependencies.
package u8cw_pkg;

  localparam int CP_W     = 21;
  localparam int LEN_W    = 3;
  localparam int WID_W    = 2;
  localparam int LEFT_W   = 2;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);
  localparam int N_WIDE   = 28;
  localparam int IN_TDW   = 8;
  localparam int OUT_TDW  = 32;

  localparam logic [7:0] CONT_MASK = 8'h3F;

  localparam logic [WID_W-1:0] WID_ZERO   = 2'd0;
  localparam logic [WID_W-1:0] WID_NARROW = 2'd1;
  localparam logic [WID_W-1:0] WID_WIDE   = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
  } char_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [Q_CW-1:0] level;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } fe_stat_t;

  localparam logic [CP_W-1:0] WIDE_LO [N_WIDE] = '{
    21'h01100, 21'h02600, 21'h02700, 21'h02E80, 21'h03000, 21'h03040, 21'h030A0,
    21'h03100, 21'h03130, 21'h031A0, 21'h031C0, 21'h03200, 21'h03300, 21'h03400,
    21'h04E00, 21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF00, 21'h1F300, 21'h1F900,
    21'h20000, 21'h2A700, 21'h2B740, 21'h2B820, 21'h2CEB0, 21'h30000, 21'hE0100
  };

  localparam logic [CP_W-1:0] WIDE_HI [N_WIDE] = '{
    21'h0115F, 21'h026FF, 21'h027FF, 21'h02EFF, 21'h0303F, 21'h0309F, 21'h030FF,
    21'h0312F, 21'h0318F, 21'h031BF, 21'h031EF, 21'h032FF, 21'h033FF, 21'h04DBF,
    21'h09FFF, 21'h0FAFF, 21'h0FE1F, 21'h0FE4F, 21'h0FFEF, 21'h1F6FF, 21'h1F9FF,
    21'h2A6DF, 21'h2B73F, 21'h2B81F, 21'h2CEAF, 21'h2EBEF, 21'h3134F, 21'hE01EF
  };

  function automatic logic [WID_W-1:0] disp_width(input logic [CP_W-1:0] cp);
    logic wide;
    wide = 1'b0;
    for (int i = 0; i < N_WIDE; i++) begin
      if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) wide = 1'b1;
    end
    if (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F) ||
        cp == 21'h2028 || cp == 21'h2029) begin
      return WID_ZERO;
    end else if (wide) begin
      return WID_WIDE;
    end else begin
      return WID_NARROW;
    end
  endfunction

endpackage

FILE: sv/u8cw_front.sv
// Front end: takes raw bytes, tracks multi-byte sequences and pushes finished characters.
// Depends on u8cw_pkg.
module u8cw_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_byte,
  input  u8cw_pkg::q_stat_t      q_stat,
  output logic                   push,
  output u8cw_pkg::char_t        push_char,
  output u8cw_pkg::fe_stat_t     fe_stat
);

  logic [u8cw_pkg::CP_W-1:0]   accum_r, accum_nxt;
  logic [u8cw_pkg::LEFT_W-1:0] left_r, left_nxt;
  logic [u8cw_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                        accept;
  logic [u8cw_pkg::CP_W-1:0]   cont_acc;

  assign in_tready      = !q_stat.full;
  assign accept         = in_tvalid && in_tready;
  assign fe_stat.busy   = (left_r != '0);
  assign cont_acc       = {accum_r[u8cw_pkg::CP_W-7:0], in_byte[5:0] & u8cw_pkg::CONT_MASK[5:0]};

  always_comb begin
    accum_nxt = accum_r;
    left_nxt  = left_r;
    len_nxt   = len_r;
    push      = 1'b0;
    push_char = '0;
    if (accept) begin
      if (left_r != '0) begin
        accum_nxt = cont_acc;
        left_nxt  = left_r - 2'd1;
        if (left_r == 2'd1) begin
          push      = 1'b1;
          push_char = '{cp: cont_acc, len: len_r};
        end
      end else if (in_byte[7:5] == 3'b110) begin
        accum_nxt = {16'd0, in_byte[4:0]};
        len_nxt   = 3'd2;
        left_nxt  = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        accum_nxt = {17'd0, in_byte[3:0]};
        len_nxt   = 3'd3;
        left_nxt  = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        accum_nxt = {18'd0, in_byte[2:0]};
        len_nxt   = 3'd4;
        left_nxt  = 2'd3;
      end else begin
        len_nxt   = 3'd1;
        accum_nxt = in_byte[7] ? '0 : {13'd0, in_byte};
        push      = 1'b1;
        push_char = '{cp: accum_nxt, len: 3'd1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      left_r  <= '0;
      len_r   <= '0;
    end else begin
      accum_r <= accum_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

FILE: sv/u8cw_queue.sv
// Short FIFO of finished characters between front end and back end.
// Depends on u8cw_pkg.
module u8cw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8cw_pkg::char_t     push_char,
  input  logic                pop,
  output u8cw_pkg::char_t     head,
  output u8cw_pkg::q_stat_t   q_stat
);

  u8cw_pkg::char_t             mem [u8cw_pkg::Q_DEPTH];
  logic [u8cw_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [u8cw_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [u8cw_pkg::Q_CW-1:0]   level_r, level_nxt;
  logic                        do_push, do_pop;

  assign q_stat.full  = (level_r == u8cw_pkg::Q_CW'(u8cw_pkg::Q_DEPTH));
  assign q_stat.empty = (level_r == '0);
  assign q_stat.level = level_r;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r + u8cw_pkg::Q_CW'(do_push) - u8cw_pkg::Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_char;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

FILE: sv/u8cw_back.sv
// Back end: width lookup on queued characters and the registered result beat.
// Depends on u8cw_pkg.
module u8cw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u8cw_pkg::q_stat_t             q_stat,
  input  u8cw_pkg::char_t               head,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [u8cw_pkg::OUT_TDW-1:0]  out_tdata
);

  logic                          valid_r, valid_nxt;
  logic [u8cw_pkg::CP_W-1:0]     cp_r;
  logic [u8cw_pkg::LEN_W-1:0]    len_r;
  logic [u8cw_pkg::WID_W-1:0]    wid_r;

  assign pop       = !q_stat.empty && (!valid_r || out_tready);
  assign valid_nxt = pop ? 1'b1 : (out_tready ? 1'b0 : valid_r);
  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, wid_r, len_r, cp_r};

  always_ff @(posedge clk) begin
    if (pop) begin
      cp_r  <= head.cp;
      len_r <= head.len;
      wid_r <= u8cw_pkg::disp_width(head.cp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

endmodule

FILE: sv/utf8_char_display_width.sv
// UTF-8 decoder with terminal display width, top level.
// Path: the last byte of a character pushes it into the queue; the back end pops it into the registered result beat.
// Throughput: one byte per cycle; a 4-entry char queue absorbs output stalls until full.
// Reset: synchronous active-low rst_n clears the decode state, queue and output valid.
// Depends on u8cw_pkg, u8cw_front, u8cw_queue, u8cw_back.
module utf8_char_display_width (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [20:0] code_point, [23:21] char_bytes, [25:24] col_width
);

  u8cw_pkg::q_stat_t  q_stat;
  u8cw_pkg::fe_stat_t fe_stat;
  u8cw_pkg::char_t    push_char, head;
  logic               push, pop;

  u8cw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_char (push_char),
    .fe_stat   (fe_stat)
  );

  u8cw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_char (push_char),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  u8cw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= u8cw_pkg::Q_CW'(u8cw_pkg::Q_DEPTH))
    else $error("queue level exceeds depth");

  a_ascii_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !fe_stat.busy && !in_tdata[7]) |=> !q_stat.empty)
    else $error("single-byte character not queued");

  a_width_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:24] != 2'b11))
    else $error("illegal display width");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:21] != 3'd0 && out_tdata[23:21] <= 3'd4))
    else $error("char_bytes out of range");

endmodule
